[hdl/gac_pkg.sv]
// ---------------------------------------------------------------------------
// gac_pkg
// types, codes and reset constants shared by the gate actuator controller
// ---------------------------------------------------------------------------
`default_nettype none

package gac_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT_TICKS       = 2'd0;
    localparam logic [1:0] CFG_AUTO_CLOSE_SCALE    = 2'd1;
    localparam logic [1:0] CFG_ITEM_FILTER_COUNT   = 2'd2;
    localparam logic [1:0] CFG_PICKUP_FILTER_COUNT = 2'd3;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_TICKS_RST       = 16'd1000;
    localparam logic [9:0]  AUTO_CLOSE_SCALE_RST    = 10'd200;
    localparam logic [7:0]  ITEM_FILTER_COUNT_RST   = 8'd2;
    localparam logic [7:0]  PICKUP_FILTER_COUNT_RST = 8'd20;

    // state reset values
    localparam logic [7:0]  HOLD_LATCH_RST      = 8'd2;
    localparam logic [17:0] AUTOCLOSE_COUNT_RST = 18'd400;

    localparam logic [7:0] FILTER_MAX = 8'd255;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_READY   = 2'd1,
        PH_WORKING = 2'd2,
        PH_END     = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        POS_UNKNOWN = 3'd0,
        POS_OPENING = 3'd1,
        POS_OPEN    = 3'd2,
        POS_CLOSING = 3'd3,
        POS_CLOSED  = 3'd4,
        POS_ERROR   = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        ACT_OPEN  = 2'd1,
        ACT_CLOSE = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        MOT_RELEASE = 2'd0,
        MOT_OPEN    = 2'd1,
        MOT_CLOSE   = 2'd2
    } motor_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [9:0]  auto_close_scale;
        logic [7:0]  item_filter_count;
        logic [7:0]  pickup_filter_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] hold_units;
        logic       open_stop;
        logic       close_stop;
        logic       item_sensor;
        logic       pickup_sensor;
    } tick_t;

    typedef struct packed {
        motor_t motor_drive;
        pos_t   gate_position;
        logic   item_event;
        logic   jam_event;
        logic   pickup_event;
    } result_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        sat_inc = (v < FILTER_MAX) ? v + 8'd1 : FILTER_MAX;
    endfunction

endpackage

`default_nettype wire

[hdl/gate_actuator_controller.sv]
// ---------------------------------------------------------------------------
// gate_actuator_controller
// one motorized gate channel stepped once per tick beat
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries one tick beat: an optional
//   open or close command with hold time and the four sensor levels
//   output channel (out_valid / out_stall) returns one result beat per tick:
//   motor drive, gate position and the item, jam and pickup event pulses
//   config channel (cfg_valid / cfg_ready) writes timeout, auto-close scale
//   and the two filter counts; ready is always high, write only when idle
// timing:
//   a tick beat lands in the input register, the tick update runs in one
//   combinational pass and the result lands in the output register
//   one tick per cycle is sustained while out_stall stays low; the state
//   update is a single pass
// reset:
//   rst_n clears the channels, loads the config reset values and puts the
//   gate in unknown position with the motor released
// stall:
//   a stalled result holds in the output register; one more tick waits in
//   the input register, then in_stall rises until the output drains
// ---------------------------------------------------------------------------
`default_nettype none

module gate_actuator_controller (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // tick input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  hold_units,
    input  wire logic        open_stop,
    input  wire logic        close_stop,
    input  wire logic        item_sensor,
    input  wire logic        pickup_sensor,

    // result output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       motor_drive,
    output logic [2:0]       gate_position,
    output logic             item_event,
    output logic             jam_event,
    output logic             pickup_event,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import gac_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    in_take;

    // output register frees up when empty or being taken this cycle
    assign advance  = !out_valid_reg || !out_stall;
    // input register holds its beat only while the output is blocked
    assign in_stall = tick_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    gac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // state advances exactly once per tick, when its result moves into the output register
    gac_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (tick_valid_reg && advance),
        .cfg    (cfg),
        .tick   (tick_reg),
        .result (core_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            tick_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg.opcode        <= opcode;
            tick_reg.hold_units    <= hold_units;
            tick_reg.open_stop     <= open_stop;
            tick_reg.close_stop    <= close_stop;
            tick_reg.item_sensor   <= item_sensor;
            tick_reg.pickup_sensor <= pickup_sensor;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tick_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tick_valid_reg)
        begin
            out_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_drive   = out_reg.motor_drive;
    assign gate_position = out_reg.gate_position;
    assign item_event    = out_reg.item_event;
    assign jam_event     = out_reg.jam_event;
    assign pickup_event  = out_reg.pickup_event;

endmodule

`default_nettype wire

[hdl/gac_cfg.sv]
// ---------------------------------------------------------------------------
// gac_cfg
// configuration register file, written one beat at a time
// ---------------------------------------------------------------------------
`default_nettype none

module gac_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [15:0]   cfg_data,
    output gac_pkg::cfg_t      cfg
);
    import gac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_TICKS:       cfg_next.timeout_ticks       = cfg_data;
                CFG_AUTO_CLOSE_SCALE:    cfg_next.auto_close_scale    = cfg_data[9:0];
                CFG_ITEM_FILTER_COUNT:   cfg_next.item_filter_count   = cfg_data[7:0];
                CFG_PICKUP_FILTER_COUNT: cfg_next.pickup_filter_count = cfg_data[7:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks       <= TIMEOUT_TICKS_RST;
            cfg_reg.auto_close_scale    <= AUTO_CLOSE_SCALE_RST;
            cfg_reg.item_filter_count   <= ITEM_FILTER_COUNT_RST;
            cfg_reg.pickup_filter_count <= PICKUP_FILTER_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hdl/gac_core.sv]
// ---------------------------------------------------------------------------
// gac_core
// gate state registers and the single-pass tick update
// ---------------------------------------------------------------------------
`default_nettype none

module gac_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire gac_pkg::cfg_t   cfg,
    input  wire gac_pkg::tick_t  tick,
    output gac_pkg::result_t     result
);
    import gac_pkg::*;

    phase_t      phase_reg,      phase_next;
    pos_t        pos_reg,        pos_next;
    act_t        act_reg,        act_next;
    motor_t      motor_reg,      motor_next;
    logic [7:0]  hold_reg,       hold_next;
    logic [15:0] timeout_reg,    timeout_next;
    logic [17:0] autoclose_reg,  autoclose_next;
    logic [7:0]  item_f_reg,     item_f_next;
    logic [7:0]  jam_f_reg,      jam_f_next;
    logic        item_rep_reg,   item_rep_next;
    logic        jam_rep_reg,    jam_rep_next;
    logic [7:0]  pick_f_reg,     pick_f_next;
    logic        pick_lat_reg,   pick_lat_next;
    logic [7:0]  rearm_f_reg,    rearm_f_next;
    logic        ev_item, ev_jam, ev_pick;
    logic [17:0] autoclose_load;

    assign autoclose_load = hold_reg * cfg.auto_close_scale;

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        act_next       = act_reg;
        motor_next     = motor_reg;
        hold_next      = hold_reg;
        timeout_next   = timeout_reg;
        autoclose_next = autoclose_reg;
        item_f_next    = item_f_reg;
        jam_f_next     = jam_f_reg;
        item_rep_next  = item_rep_reg;
        jam_rep_next   = jam_rep_reg;
        pick_f_next    = pick_f_reg;
        pick_lat_next  = pick_lat_reg;
        rearm_f_next   = rearm_f_reg;
        ev_item        = 1'b0;
        ev_jam         = 1'b0;
        ev_pick        = 1'b0;

        // command restarts the sequence
        if (tick.opcode == OP_OPEN)
        begin
            act_next   = ACT_OPEN;
            hold_next  = tick.hold_units;
            phase_next = PH_READY;
        end
        else if (tick.opcode == OP_CLOSE)
        begin
            act_next   = ACT_CLOSE;
            phase_next = PH_READY;
        end

        // phase step
        unique case (phase_next)
            PH_IDLE:
            begin
                timeout_next = '0;
                if (autoclose_reg == '0 && pos_reg == POS_OPEN)
                begin
                    phase_next = PH_READY;
                    act_next   = ACT_CLOSE;
                end
            end
            PH_READY:
            begin
                unique case (act_next)
                    ACT_OPEN:
                    begin
                        motor_next = MOT_OPEN;
                        pos_next   = POS_OPENING;
                    end
                    ACT_CLOSE:
                    begin
                        motor_next = MOT_CLOSE;
                        pos_next   = POS_CLOSING;
                    end
                    default: ;
                endcase
                timeout_next = cfg.timeout_ticks;
                phase_next   = PH_WORKING;
            end
            PH_WORKING:
            begin
                if (timeout_reg == '0)
                begin
                    if (pos_reg == POS_OPENING)
                    begin
                        phase_next = PH_END;
                        motor_next = MOT_RELEASE;
                        pos_next   = POS_ERROR;
                    end
                end
                else
                begin
                    timeout_next = timeout_reg - 16'd1;
                end
            end
            default:
            begin
                if (pos_reg == POS_OPEN)
                begin
                    autoclose_next = autoclose_load;
                end
                phase_next = PH_IDLE;
            end
        endcase

        // end-stops
        if (pos_next == POS_OPENING)
        begin
            if (tick.open_stop)
            begin
                motor_next = MOT_RELEASE;
                pos_next   = POS_OPEN;
                phase_next = PH_END;
            end
            jam_rep_next = 1'b0;
        end
        if (pos_next == POS_CLOSING)
        begin
            if (tick.close_stop)
            begin
                motor_next = MOT_RELEASE;
                pos_next   = POS_CLOSED;
                phase_next = PH_END;
            end
            item_rep_next = 1'b0;
        end

        // item and jam filters
        if (tick.item_sensor)
        begin
            if (pos_next == POS_OPEN || pos_next == POS_OPENING)
            begin
                item_f_next = sat_inc(item_f_reg);
                if (item_f_next >= cfg.item_filter_count && !item_rep_next)
                begin
                    ev_item       = 1'b1;
                    item_f_next   = '0;
                    item_rep_next = 1'b1;
                end
            end
            else if (pos_next == POS_CLOSING)
            begin
                jam_f_next = sat_inc(jam_f_reg);
                if (jam_f_next >= cfg.item_filter_count && !jam_rep_next)
                begin
                    ev_jam       = 1'b1;
                    jam_f_next   = '0;
                    jam_rep_next = 1'b1;
                    motor_next   = MOT_RELEASE;
                end
            end
        end
        else
        begin
            item_f_next = '0;
            jam_f_next  = '0;
        end

        if (autoclose_next != '0)
        begin
            autoclose_next = autoclose_next - 18'd1;
        end

        // pickup filter, sensor active low
        if (!tick.pickup_sensor)
        begin
            if (!pick_lat_reg)
            begin
                pick_f_next = sat_inc(pick_f_reg);
                if (pick_f_next > cfg.pickup_filter_count)
                begin
                    ev_pick       = 1'b1;
                    pick_lat_next = 1'b1;
                    pick_f_next   = '0;
                end
            end
        end
        else if (pick_lat_reg)
        begin
            rearm_f_next = sat_inc(rearm_f_reg);
            if (rearm_f_next > cfg.pickup_filter_count)
            begin
                pick_lat_next = 1'b0;
                rearm_f_next  = '0;
            end
        end
    end

    always_comb
    begin
        result.motor_drive   = motor_next;
        result.gate_position = pos_next;
        result.item_event    = ev_item;
        result.jam_event     = ev_jam;
        result.pickup_event  = ev_pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= POS_UNKNOWN;
            act_reg       <= ACT_OPEN;
            motor_reg     <= MOT_RELEASE;
            hold_reg      <= HOLD_LATCH_RST;
            timeout_reg   <= '0;
            autoclose_reg <= AUTOCLOSE_COUNT_RST;
            item_f_reg    <= '0;
            jam_f_reg     <= '0;
            item_rep_reg  <= 1'b0;
            jam_rep_reg   <= 1'b0;
            pick_f_reg    <= '0;
            pick_lat_reg  <= 1'b0;
            rearm_f_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            act_reg       <= act_next;
            motor_reg     <= motor_next;
            hold_reg      <= hold_next;
            timeout_reg   <= timeout_next;
            autoclose_reg <= autoclose_next;
            item_f_reg    <= item_f_next;
            jam_f_reg     <= jam_f_next;
            item_rep_reg  <= item_rep_next;
            jam_rep_reg   <= jam_rep_next;
            pick_f_reg    <= pick_f_next;
            pick_lat_reg  <= pick_lat_next;
            rearm_f_reg   <= rearm_f_next;
        end
    end

endmodule

`default_nettype wire

[test/gac_checker.sv]
// ---------------------------------------------------------------------------
// gac_checker
// watches the tick, result and config channels of the gate controller,
// keeps its own model of the gate and compares every result beat against it
// ---------------------------------------------------------------------------
`default_nettype none

module gac_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  hold_units,
    input  wire logic        open_stop,
    input  wire logic        close_stop,
    input  wire logic        item_sensor,
    input  wire logic        pickup_sensor,

    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  motor_drive,
    input  wire logic [2:0]  gate_position,
    input  wire logic        item_event,
    input  wire logic        jam_event,
    input  wire logic        pickup_event,

    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    output int               reports_waiting,
    output int               mismatches
);
    import gac_pkg::*;

    // limits as written over the config channel
    logic [15:0] lim_timeout;
    logic [9:0]  lim_scale;
    logic [7:0]  lim_item;
    logic [7:0]  lim_pickup;

    // gate model
    phase_t      phase;
    pos_t        gate_pos;
    act_t        next_act;
    motor_t      motor_q;
    logic [7:0]  held_units;
    logic [15:0] travel_left;
    logic [17:0] close_delay;
    logic [7:0]  item_cnt;
    logic [7:0]  jam_cnt;
    logic        item_seen;
    logic        jam_seen;
    logic [7:0]  pick_cnt;
    logic        pick_latched;
    logic [7:0]  rearm_cnt;

    result_t     gate_reports[$];
    tick_t       beat_in;
    result_t     want;

    function automatic logic [7:0] bump(input logic [7:0] v);
        bump = (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // one tick of the gate: command, phase step, end-stops, filters
    function automatic result_t advance_gate(input tick_t t);
        result_t r;
        r = '0;

        if (t.opcode == OP_OPEN)
        begin
            next_act   = ACT_OPEN;
            held_units = t.hold_units;
            phase      = PH_READY;
        end
        else if (t.opcode == OP_CLOSE)
        begin
            next_act = ACT_CLOSE;
            phase    = PH_READY;
        end

        case (phase)
            PH_IDLE:
            begin
                travel_left = '0;
                if (close_delay == '0 && gate_pos == POS_OPEN)
                begin
                    phase    = PH_READY;
                    next_act = ACT_CLOSE;
                end
            end
            PH_READY:
            begin
                if (next_act == ACT_OPEN)
                begin
                    motor_q  = MOT_OPEN;
                    gate_pos = POS_OPENING;
                end
                else
                begin
                    motor_q  = MOT_CLOSE;
                    gate_pos = POS_CLOSING;
                end
                travel_left = lim_timeout;
                phase       = PH_WORKING;
            end
            PH_WORKING:
            begin
                if (travel_left == '0)
                begin
                    if (gate_pos == POS_OPENING)
                    begin
                        phase    = PH_END;
                        motor_q  = MOT_RELEASE;
                        gate_pos = POS_ERROR;
                    end
                end
                else
                begin
                    travel_left = travel_left - 16'd1;
                end
            end
            default:
            begin
                if (gate_pos == POS_OPEN)
                    close_delay = held_units * lim_scale;
                phase = PH_IDLE;
            end
        endcase

        if (gate_pos == POS_OPENING)
        begin
            if (t.open_stop)
            begin
                motor_q  = MOT_RELEASE;
                gate_pos = POS_OPEN;
                phase    = PH_END;
            end
            jam_seen = 1'b0;
        end
        if (gate_pos == POS_CLOSING)
        begin
            if (t.close_stop)
            begin
                motor_q  = MOT_RELEASE;
                gate_pos = POS_CLOSED;
                phase    = PH_END;
            end
            item_seen = 1'b0;
        end

        if (t.item_sensor)
        begin
            if (gate_pos == POS_OPEN || gate_pos == POS_OPENING)
            begin
                item_cnt = bump(item_cnt);
                if (item_cnt >= lim_item && !item_seen)
                begin
                    r.item_event = 1'b1;
                    item_cnt     = '0;
                    item_seen    = 1'b1;
                end
            end
            else if (gate_pos == POS_CLOSING)
            begin
                jam_cnt = bump(jam_cnt);
                if (jam_cnt >= lim_item && !jam_seen)
                begin
                    r.jam_event = 1'b1;
                    jam_cnt     = '0;
                    jam_seen    = 1'b1;
                    motor_q     = MOT_RELEASE;
                end
            end
        end
        else
        begin
            item_cnt = '0;
            jam_cnt  = '0;
        end

        if (close_delay != '0)
            close_delay = close_delay - 18'd1;

        // pickup sensor is active low
        if (!t.pickup_sensor)
        begin
            if (!pick_latched)
            begin
                pick_cnt = bump(pick_cnt);
                if (pick_cnt > lim_pickup)
                begin
                    r.pickup_event = 1'b1;
                    pick_latched   = 1'b1;
                    pick_cnt       = '0;
                end
            end
        end
        else if (pick_latched)
        begin
            rearm_cnt = bump(rearm_cnt);
            if (rearm_cnt > lim_pickup)
            begin
                pick_latched = 1'b0;
                rearm_cnt    = '0;
            end
        end

        r.motor_drive   = motor_q;
        r.gate_position = gate_pos;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_timeout  = TIMEOUT_TICKS_RST;
            lim_scale    = AUTO_CLOSE_SCALE_RST;
            lim_item     = ITEM_FILTER_COUNT_RST;
            lim_pickup   = PICKUP_FILTER_COUNT_RST;
            phase        = PH_IDLE;
            gate_pos     = POS_UNKNOWN;
            next_act     = ACT_OPEN;
            motor_q      = MOT_RELEASE;
            held_units   = HOLD_LATCH_RST;
            travel_left  = '0;
            close_delay  = AUTOCLOSE_COUNT_RST;
            item_cnt     = '0;
            jam_cnt      = '0;
            item_seen    = 1'b0;
            jam_seen     = 1'b0;
            pick_cnt     = '0;
            pick_latched = 1'b0;
            rearm_cnt    = '0;
            gate_reports.delete();
            mismatches      <= 0;
            reports_waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS:       lim_timeout = cfg_data;
                    CFG_AUTO_CLOSE_SCALE:    lim_scale   = cfg_data[9:0];
                    CFG_ITEM_FILTER_COUNT:   lim_item    = cfg_data[7:0];
                    CFG_PICKUP_FILTER_COUNT: lim_pickup  = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (gate_reports.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result beat with nothing due: motor %0d pos %0d ev %b%b%b",
                                 motor_drive, gate_position,
                                 item_event, jam_event, pickup_event);
                end
                else
                begin
                    want = gate_reports.pop_front();
                    if (motor_drive !== want.motor_drive ||
                        gate_position !== want.gate_position ||
                        item_event !== want.item_event ||
                        jam_event !== want.jam_event ||
                        pickup_event !== want.pickup_event)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: want %0d/%0d/%b%b%b got %0d/%0d/%b%b%b",
                                     want.motor_drive, want.gate_position,
                                     want.item_event, want.jam_event, want.pickup_event,
                                     motor_drive, gate_position,
                                     item_event, jam_event, pickup_event);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                beat_in.opcode        = opcode;
                beat_in.hold_units    = hold_units;
                beat_in.open_stop     = open_stop;
                beat_in.close_stop    = close_stop;
                beat_in.item_sensor   = item_sensor;
                beat_in.pickup_sensor = pickup_sensor;
                gate_reports.push_back(advance_gate(beat_in));
            end

            reports_waiting <= gate_reports.size();
        end
    end

endmodule

`default_nettype wire

[test/tb_gate_actuator_controller.sv]
// ---------------------------------------------------------------------------
// tb_gate_actuator_controller
// drives tick beats into the gate controller and gives the verdict
// ---------------------------------------------------------------------------
// a short directed run covers the field extremes, every opcode, auto-close,
// timeout on opening and closing, jam and pickup; then random open and close
// cycles, timeouts, interrupted travel and noise run under several limit
// settings. a checker beside the block predicts and compares each result
// ---------------------------------------------------------------------------
`default_nettype none

module tb_gate_actuator_controller;
    import gac_pkg::*;

    // opcode with no command, behaves as a plain tick
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;

    logic        in_valid      = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode        = OP_TICK;
    logic [7:0]  hold_units    = '0;
    logic        open_stop     = 1'b0;
    logic        close_stop    = 1'b0;
    logic        item_sensor   = 1'b0;
    logic        pickup_sensor = 1'b1;

    logic        out_valid;
    logic        out_stall     = 1'b0;
    logic [1:0]  motor_drive;
    logic [2:0]  gate_position;
    logic        item_event;
    logic        jam_event;
    logic        pickup_event;

    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = CFG_TIMEOUT_TICKS;
    logic [15:0] cfg_data      = '0;

    int          reports_waiting;
    int          mismatches;

    // limits currently programmed, used to shape the stimulus
    int          cur_tmo   = 1000;
    int          cur_scale = 200;
    int          cur_ifc   = 2;
    int          cur_pfc   = 20;

    // sender burst state
    int          burst_left = 0;
    int          beats_sent = 0;

    // sensor level runs
    bit          item_lvl  = 1'b0;
    int          item_run  = 0;
    bit          pick_lvl  = 1'b1;
    int          pick_run  = 0;

    // receiver stall pattern state
    int          stall_mode = 0;
    int          stall_left = 0;

    gate_actuator_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .hold_units    (hold_units),
        .open_stop     (open_stop),
        .close_stop    (close_stop),
        .item_sensor   (item_sensor),
        .pickup_sensor (pickup_sensor),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .motor_drive   (motor_drive),
        .gate_position (gate_position),
        .item_event    (item_event),
        .jam_event     (jam_event),
        .pickup_event  (pickup_event),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gac_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .hold_units      (hold_units),
        .open_stop       (open_stop),
        .close_stop      (close_stop),
        .item_sensor     (item_sensor),
        .pickup_sensor   (pickup_sensor),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .motor_drive     (motor_drive),
        .gate_position   (gate_position),
        .item_event      (item_event),
        .jam_event       (jam_event),
        .pickup_event    (pickup_event),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .reports_waiting (reports_waiting),
        .mismatches      (mismatches)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stall: free-running modes of random length
    // 0 never, 1 light random, 2 periodic two-of-four, 3 heavy random
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            2:       out_stall <= ((stall_left % 4) < 2);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // one tick beat; bursts of random length with random gaps in between
    task automatic send_tick(input logic [1:0] op, input logic [7:0] hold,
                             input logic os, input logic cs,
                             input logic item, input logic pick);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            // a quarter of the bursts follow the previous one back to back
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid      <= 1'b1;
        opcode        <= op;
        hold_units    <= hold;
        open_stop     <= os;
        close_stop    <= cs;
        item_sensor   <= item;
        pickup_sensor <= pick;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    // tick beat with item and pickup levels taken from random runs
    task automatic tick(input logic [1:0] op, input logic [7:0] hold,
                        input logic os, input logic cs);
        int cap_i;
        int cap_p;
        cap_i = (cur_ifc > 40) ? 40 : cur_ifc;
        cap_p = (cur_pfc > 40) ? 40 : cur_pfc;
        if (item_run == 0)
        begin
            item_lvl = ~item_lvl;
            item_run = item_lvl ? $urandom_range(1, cap_i + 3) : $urandom_range(1, 8);
        end
        item_run--;
        // pickup is active low, low runs are random and at times long enough to cross the filter
        if (pick_run == 0)
        begin
            pick_lvl = ~pick_lvl;
            pick_run = pick_lvl ? $urandom_range(1, cap_p + 8) : $urandom_range(1, cap_p + 4);
        end
        pick_run--;
        send_tick(op, hold, os, cs, item_lvl, pick_lvl);
    endtask

    // hold the sender until every result has come back, then settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // all four limits, only while the block is idle
    task automatic write_limits(input logic [15:0] tmo, input logic [9:0] scale,
                                input logic [7:0] ifc, input logic [7:0] pfc);
        put_reg(CFG_TIMEOUT_TICKS, tmo);
        put_reg(CFG_AUTO_CLOSE_SCALE, {6'd0, scale});
        put_reg(CFG_ITEM_FILTER_COUNT, {8'd0, ifc});
        put_reg(CFG_PICKUP_FILTER_COUNT, {8'd0, pfc});
        cfg_valid <= 1'b0;
        cur_tmo   = tmo;
        cur_scale = scale;
        cur_ifc   = ifc;
        cur_pfc   = pfc;
    endtask

    // random traffic: mostly full gate cycles, some timeouts,
    // interrupted travel and raw noise
    task automatic run_traffic(input int n_beats);
        int         start;
        int         kind;
        int         k;
        int         wait_n;
        bit         auto_wait;
        logic [7:0] h;
        start = beats_sent;
        while (beats_sent - start < n_beats)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                // open, travel, dwell, then close by command or by auto-close
                h = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 3));
                tick(OP_OPEN, h, 1'b0, 1'b0);
                repeat ($urandom_range(0, 10))
                    tick(OP_TICK, 8'($urandom), 1'b0, ($urandom_range(0, 15) == 0));
                repeat ($urandom_range(1, 3))
                    tick(OP_TICK, 8'($urandom), 1'b1, 1'b0);
                auto_wait = (int'(h) * cur_scale <= 120) && ($urandom_range(0, 1) == 1);
                wait_n = auto_wait ? int'(h) * cur_scale + 3 : $urandom_range(0, 15);
                repeat (wait_n)
                    tick(OP_TICK, 8'($urandom), 1'($urandom), 1'b0);
                if (!auto_wait)
                    tick(OP_CLOSE, 8'($urandom), 1'b1, 1'b0);
                repeat ($urandom_range(0, 10))
                    tick(OP_TICK, 8'($urandom), ($urandom_range(0, 15) == 0), 1'b0);
                repeat ($urandom_range(1, 3))
                    tick(OP_TICK, 8'($urandom), 1'b0, 1'b1);
            end
            else if (kind < 15)
            begin
                // no end-stop: with a short timeout opening runs into error, closing just waits
                k = (cur_tmo <= 40) ? cur_tmo + 3 : $urandom_range(5, 20);
                tick(OP_OPEN, 8'($urandom), 1'b0, 1'b0);
                repeat (k) tick(OP_TICK, 8'($urandom), 1'b0, 1'b0);
                tick(OP_CLOSE, 8'($urandom), 1'b0, 1'b0);
                repeat (k) tick(OP_TICK, 8'($urandom), 1'b0, 1'b0);
                tick(OP_TICK, 8'($urandom), 1'b0, 1'b1);
            end
            else if (kind < 17)
            begin
                // commands that land in the middle of travel
                tick(OP_OPEN, 8'($urandom_range(0, 3)), 1'b0, 1'b0);
                repeat ($urandom_range(0, 4)) tick(OP_TICK, 8'($urandom), 1'b0, 1'b0);
                tick(OP_CLOSE, 8'($urandom), 1'b0, 1'b0);
                repeat ($urandom_range(0, 4)) tick(OP_TICK, 8'($urandom), 1'b0, 1'b0);
                tick(OP_OPEN, 8'($urandom_range(0, 3)), 1'b0, 1'b0);
                repeat ($urandom_range(2, 8))
                    tick(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else
            begin
                // raw noise over every field, reserved opcode included
                repeat ($urandom_range(4, 16))
                    send_tick(2'($urandom), 8'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom), 1'($urandom));
            end
            // now and then let the pipe run dry mid-phase
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        int ph;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tight limits so every path shows up within a few beats
        write_limits(16'd3, 10'd1, 8'd1, 8'd1);

        // reserved opcode with every sensor and hold bit high
        send_tick(OP_RESERVED, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1);
        // pickup low twice fires the pickup pulse, high twice rearms
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        // open with item present, no end-stop: item pulse, then timeout error
        send_tick(OP_OPEN, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b1);
        repeat (4) send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        // open with zero hold reaching the stop: auto-close right away
        send_tick(OP_OPEN, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1);
        send_tick(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        // item while closing: jam releases the motor
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
        // close from closed, then no stop: timeout while closing does nothing
        send_tick(OP_CLOSE, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        repeat (5) send_tick(OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
        // commands restarting the sequence mid-travel
        send_tick(OP_CLOSE, 8'h80, 1'b0, 1'b1, 1'b0, 1'b1);
        send_tick(OP_OPEN, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // random phases: reset values, both extremes, then random limits
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: write_limits(TIMEOUT_TICKS_RST, AUTO_CLOSE_SCALE_RST,
                                ITEM_FILTER_COUNT_RST, PICKUP_FILTER_COUNT_RST);
                1: write_limits(16'd1, 10'd1, 8'd1, 8'd1);
                2: write_limits(16'hFFFF, 10'h3FF, 8'hFF, 8'hFF);
                3, 5: write_limits(16'($urandom_range(2, 30)), 10'($urandom_range(1, 4)),
                                   8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)));
                default: write_limits(16'($urandom_range(1, 65535)),
                                      10'($urandom_range(1, 1023)),
                                      8'($urandom_range(1, 255)),
                                      8'($urandom_range(1, 255)));
            endcase
            run_traffic(210);
            wait_drained();
        end

        if (mismatches == 0 && reports_waiting == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
